// ===== rtl/core/emd_pkg.sv =====
// Shared types, widths and helper functions of the element measure pipeline.
package emd_pkg;

   // Coordinate and arithmetic widths.
   localparam int COORD_WIDTH   = 24;
   localparam int FRACTION_BITS = 12;
   localparam int DIFF_WIDTH    = COORD_WIDTH + 1;
   localparam int PROD_WIDTH    = 2 * DIFF_WIDTH;
   localparam int MEASURE_WIDTH = 50;
   localparam int ROOT_WIDTH    = DIFF_WIDTH;
   localparam int TEST_WIDTH    = PROD_WIDTH + 1;

   // Cycles from an accepted item to its result strobe being sampled.
   localparam int LATENCY = 5 + ROOT_WIDTH;

   // Figure codes.
   typedef enum logic [1:0] {
      FIG_LINE = 2'd0,
      FIG_TRI  = 2'd1,
      FIG_QUAD = 2'd2,
      FIG_BAD  = 2'd3
   } fig_type;

   // Control that travels with every item.
   typedef struct packed {
      logic    valid;
      fig_type fig;
   } ctrl_type;

   // Four product operand pairs selected for one item.
   typedef struct packed {
      logic signed [3:0][DIFF_WIDTH-1:0] u;
      logic signed [3:0][DIFF_WIDTH-1:0] v;
   } ops_type;

   // Combined value ahead of the root pipeline: squared length or area.
   typedef struct packed {
      ctrl_type                 ctrl;
      logic [PROD_WIDTH-1:0]    val;
   } val_type;

   // One stage of the digit-by-digit square root.
   typedef struct packed {
      ctrl_type                 ctrl;
      logic [PROD_WIDTH-1:0]    rem;
      logic [ROOT_WIDTH-1:0]    root;
   } root_stage_type;

   // Difference of two coordinates, one bit wider than a coordinate.
   function automatic logic signed [DIFF_WIDTH-1:0] coord_sub(
      input logic signed [COORD_WIDTH-1:0] a,
      input logic signed [COORD_WIDTH-1:0] b
   );
      logic signed [DIFF_WIDTH-1:0] ax;
      logic signed [DIFF_WIDTH-1:0] bx;
      ax = {a[COORD_WIDTH-1], a};
      bx = {b[COORD_WIDTH-1], b};
      return ax - bx;
   endfunction

endpackage

// ===== rtl/core/emd_operand.sv =====
// First pipeline stage: node differences and product operand selection.
module emd_operand (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        load,
   input  logic [1:0]                                  figure,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]      x0,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]      y0,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]      x1,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]      y1,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]      x2,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]      y2,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]      x3,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]      y3,
   output emd_pkg::ctrl_type                           ctrl_out,
   output emd_pkg::ops_type                            ops_out
);

   emd_pkg::ctrl_type ctrl_ff, ctrl_in;
   emd_pkg::ops_type  ops_ff, ops_in;

   // Pick the operand pairs so that cross = u0*v0 - u1*v1 (and u2*v2 - u3*v3).
   // A line instead squares dx and dy; unused pairs stay zero.
   always_comb begin
      ctrl_in.valid = load;
      ctrl_in.fig   = emd_pkg::fig_type'(figure);
      ops_in        = '0;
      unique case (ctrl_in.fig)
         emd_pkg::FIG_LINE: begin
            ops_in.u[0] = emd_pkg::coord_sub(x1, x0);
            ops_in.v[0] = emd_pkg::coord_sub(x1, x0);
            ops_in.u[1] = emd_pkg::coord_sub(y1, y0);
            ops_in.v[1] = emd_pkg::coord_sub(y1, y0);
         end
         emd_pkg::FIG_TRI: begin
            ops_in.u[0] = emd_pkg::coord_sub(x1, x0);
            ops_in.v[0] = emd_pkg::coord_sub(y2, y0);
            ops_in.u[1] = emd_pkg::coord_sub(y1, y0);
            ops_in.v[1] = emd_pkg::coord_sub(x2, x0);
         end
         emd_pkg::FIG_QUAD: begin
            ops_in.u[0] = emd_pkg::coord_sub(x0, x1);
            ops_in.v[0] = emd_pkg::coord_sub(y2, y1);
            ops_in.u[1] = emd_pkg::coord_sub(y0, y1);
            ops_in.v[1] = emd_pkg::coord_sub(x2, x1);
            ops_in.u[2] = emd_pkg::coord_sub(x2, x3);
            ops_in.v[2] = emd_pkg::coord_sub(y0, y3);
            ops_in.u[3] = emd_pkg::coord_sub(y2, y3);
            ops_in.v[3] = emd_pkg::coord_sub(x0, x3);
         end
         default: begin
            ops_in = '0;
         end
      endcase
   end

   // Stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      ctrl_ff.fig <= ctrl_in.fig;
      ops_ff      <= ops_in;
   end

   assign ctrl_out = ctrl_ff;
   assign ops_out  = ops_ff;

endmodule

// ===== rtl/core/emd_mult.sv =====
// Multiply, cross-product magnitude and area halving stages.
module emd_mult (
   input  logic                 clock,
   input  logic                 reset,
   input  emd_pkg::ctrl_type    ctrl_in_data,
   input  emd_pkg::ops_type     ops_in_data,
   output emd_pkg::val_type     val_out
);

   localparam int PW = emd_pkg::PROD_WIDTH;

   emd_pkg::ctrl_type           prod_ctrl_ff;
   logic signed [3:0][PW-1:0]   prod_ff, prod_in;
   emd_pkg::ctrl_type           mag_ctrl_ff;
   logic [PW-1:0]               mag0_ff, mag0_in;
   logic [PW-1:0]               mag1_ff, mag1_in;
   emd_pkg::val_type            val_ff, val_in;
   logic signed [PW:0]          diff0;
   logic signed [PW:0]          diff1;
   logic signed [PW:0]          neg0;
   logic signed [PW:0]          neg1;
   logic [PW:0]                 area_sum;

   // Four independent signed products. Elements of a packed array read as
   // unsigned, so each operand is taken as a signed difference here.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod_in[k] = $signed(ops_in_data.u[k]) * $signed(ops_in_data.v[k]);
      end
   end

   // Cross-product magnitudes; a line adds its two squares instead.
   always_comb begin
      diff0 = {prod_ff[0][PW-1], prod_ff[0]} - {prod_ff[1][PW-1], prod_ff[1]};
      diff1 = {prod_ff[2][PW-1], prod_ff[2]} - {prod_ff[3][PW-1], prod_ff[3]};
      neg0  = -diff0;
      neg1  = -diff1;
      if (prod_ctrl_ff.fig == emd_pkg::FIG_LINE) begin
         mag0_in = prod_ff[0] + prod_ff[1];
         mag1_in = '0;
      end else begin
         mag0_in = diff0[PW] ? neg0[PW-1:0] : diff0[PW-1:0];
         mag1_in = diff1[PW] ? neg1[PW-1:0] : diff1[PW-1:0];
      end
   end

   // Area is the halved sum of the magnitudes; a line passes its square sum.
   always_comb begin
      area_sum    = {1'b0, mag0_ff} + {1'b0, mag1_ff};
      val_in.ctrl = mag_ctrl_ff;
      if (mag_ctrl_ff.fig == emd_pkg::FIG_LINE) begin
         val_in.val = mag0_ff;
      end else begin
         val_in.val = area_sum[PW:1];
      end
   end

   // Stage registers: valid bits reset, payload does not.
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ctrl_ff.valid <= 1'b0;
         mag_ctrl_ff.valid  <= 1'b0;
         val_ff.ctrl.valid  <= 1'b0;
      end else begin
         prod_ctrl_ff.valid <= ctrl_in_data.valid;
         mag_ctrl_ff.valid  <= prod_ctrl_ff.valid;
         val_ff.ctrl.valid  <= val_in.ctrl.valid;
      end
      prod_ctrl_ff.fig <= ctrl_in_data.fig;
      prod_ff          <= prod_in;
      mag_ctrl_ff.fig  <= prod_ctrl_ff.fig;
      mag0_ff          <= mag0_in;
      mag1_ff          <= mag1_in;
      val_ff.ctrl.fig  <= val_in.ctrl.fig;
      val_ff.val       <= val_in.val;
   end

   assign val_out = val_ff;

endmodule

// ===== rtl/core/emd_root.sv =====
// Square root pipeline, one result bit per stage, and the result register.
module emd_root (
   input  logic                                       clock,
   input  logic                                       reset,
   input  emd_pkg::val_type                           val_in_data,
   output logic                                       out_valid,
   output logic [emd_pkg::MEASURE_WIDTH-1:0]          out_measure,
   output logic                                       out_bad
);

   localparam int RW = emd_pkg::ROOT_WIDTH;
   localparam int PW = emd_pkg::PROD_WIDTH;
   localparam int TW = emd_pkg::TEST_WIDTH;

   emd_pkg::root_stage_type stage_ff [RW];
   emd_pkg::root_stage_type stage_in [RW];
   emd_pkg::root_stage_type head;

   logic                              valid_ff;
   logic [emd_pkg::MEASURE_WIDTH-1:0] measure_ff, measure_in;
   logic                              bad_ff, bad_in;

   // Entry of the chain: the value becomes the starting remainder.
   always_comb begin
      head.ctrl = val_in_data.ctrl;
      head.rem  = val_in_data.val;
      head.root = '0;
   end

   // Each stage decides one root bit, most significant first.
   // Items that are not lines pass through untouched.
   for (genvar k = 0; k < RW; k++) begin : g_digit
      localparam int BIT = RW - 1 - k;
      emd_pkg::root_stage_type prev;
      logic [TW-1:0]           trial;

      assign prev = (k == 0) ? head : stage_ff[(k == 0) ? 0 : k - 1];

      always_comb begin
         trial       = (TW'(prev.root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
         stage_in[k] = prev;
         if (prev.ctrl.fig == emd_pkg::FIG_LINE && TW'(prev.rem) >= trial) begin
            stage_in[k].rem  = PW'(TW'(prev.rem) - trial);
            stage_in[k].root = prev.root | (RW'(1) << BIT);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k].ctrl.valid <= 1'b0;
         end else begin
            stage_ff[k].ctrl.valid <= stage_in[k].ctrl.valid;
         end
         stage_ff[k].ctrl.fig <= stage_in[k].ctrl.fig;
         stage_ff[k].rem      <= stage_in[k].rem;
         stage_ff[k].root     <= stage_in[k].root;
      end
   end

   // Result selection by figure.
   always_comb begin
      bad_in = 1'b0;
      unique case (stage_ff[RW-1].ctrl.fig)
         emd_pkg::FIG_LINE: begin
            measure_in = emd_pkg::MEASURE_WIDTH'(stage_ff[RW-1].root);
         end
         emd_pkg::FIG_TRI,
         emd_pkg::FIG_QUAD: begin
            measure_in = emd_pkg::MEASURE_WIDTH'(stage_ff[RW-1].rem);
         end
         default: begin
            measure_in = '0;
            bad_in     = 1'b1;
         end
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_ff[RW-1].ctrl.valid;
      end
      measure_ff <= measure_in;
      bad_ff     <= bad_in;
   end

   assign out_valid   = valid_ff;
   assign out_measure = measure_ff;
   assign out_bad     = bad_ff;

endmodule

// ===== rtl/core/element_measure_2d.sv =====
// Top level of the 2D mesh element measure pipeline.
//
// One element enters per cycle whenever start is high; busy is never raised, so
// the block takes a new item in every cycle. Each item gives exactly one result,
// strobed by rsp_valid for one cycle, in input order. On its way it passes the
// four arithmetic stages (differences, multipliers, cross magnitudes, halving),
// the 25-stage square root chain that every item walks through, one root bit per
// stage, and the result register. Lines give their length in Q13.12, triangles
// and quadrilaterals their area in Q24.24, and the unsupported figure code gives
// a measure of zero with rsp_bad_figure set. The receiver cannot stall the
// results, and the block needs none of its own.
module element_measure_2d (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic [1:0]                                 req_figure,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]     req_x0,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]     req_y0,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]     req_x1,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]     req_y1,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]     req_x2,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]     req_y2,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]     req_x3,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]     req_y3,
   output logic                                       rsp_valid,
   output logic [emd_pkg::MEASURE_WIDTH-1:0]          rsp_measure,
   output logic                                       rsp_bad_figure
);

   emd_pkg::ctrl_type op_ctrl;
   emd_pkg::ops_type  op_data;
   emd_pkg::val_type  val_data;
   logic              accept;

   // The pipeline never stalls.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Differences and operand selection.
   emd_operand u_operand (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .figure   (req_figure),
      .x0       (req_x0),
      .y0       (req_y0),
      .x1       (req_x1),
      .y1       (req_y1),
      .x2       (req_x2),
      .y2       (req_y2),
      .x3       (req_x3),
      .y3       (req_y3),
      .ctrl_out (op_ctrl),
      .ops_out  (op_data)
   );

   // Products, magnitudes and area.
   emd_mult u_mult (
      .clock        (clock),
      .reset        (reset),
      .ctrl_in_data (op_ctrl),
      .ops_in_data  (op_data),
      .val_out      (val_data)
   );

   // Square root chain and result register.
   emd_root u_root (
      .clock       (clock),
      .reset       (reset),
      .val_in_data (val_data),
      .out_valid   (rsp_valid),
      .out_measure (rsp_measure),
      .out_bad     (rsp_bad_figure)
   );

   // Every accepted item comes out after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(emd_pkg::LATENCY) rsp_valid)
      else $error("accepted item did not produce a result on time");

   // A result with no item accepted at the matching edge is invented.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      accept == 1'b0 |-> ##(emd_pkg::LATENCY) !rsp_valid ||
      $past(reset, emd_pkg::LATENCY - 1))
      else $error("result without an accepted item");

   // An unsupported figure gives a measure of zero.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_figure |-> rsp_measure == '0)
      else $error("unsupported figure with nonzero measure");

   // No measure reaches the top bit at these coordinate widths.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_measure[emd_pkg::MEASURE_WIDTH-1])
      else $error("measure out of range");

endmodule

// ===== dv/element_measure_2d_checker.sv =====
// Scoreboard for element_measure_2d: predicts each element's measure and compares it.
`timescale 1ns / 1ps

module element_measure_2d_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic                                     busy,
   input  logic [1:0]                               req_figure,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]   req_x0,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]   req_y0,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]   req_x1,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]   req_y1,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]   req_x2,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]   req_y2,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]   req_x3,
   input  logic signed [emd_pkg::COORD_WIDTH-1:0]   req_y3,
   input  logic                                     rsp_valid,
   input  logic [emd_pkg::MEASURE_WIDTH-1:0]        rsp_measure,
   input  logic                                     rsp_bad_figure,
   output int                                       mismatch_count,
   output int                                       pending_count,
   output int                                       checked_count
);

   localparam longint unsigned MEASURE_MAX =
      (64'd1 << emd_pkg::MEASURE_WIDTH) - 64'd1;

   typedef struct packed {
      logic [emd_pkg::MEASURE_WIDTH-1:0] measure;
      logic                              bad_figure;
   } element_result_type;

   // Measures of accepted elements, oldest first.
   element_result_type pending_measures[$];

   // Absolute value of the 2D cross product of u and v.
   function automatic longint unsigned cross_abs(
      input longint signed ux,
      input longint signed uy,
      input longint signed vx,
      input longint signed vy
   );
      longint signed c;
      c = ux * vy - uy * vx;
      return (c < 0) ? longint'(-c) : longint'(c);
   endfunction

   // Floor of the square root, built one root bit at a time from the top.
   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 26; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= n) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // Expected measure of one element.
   function automatic element_result_type measure_element(
      input emd_pkg::fig_type fig,
      input longint signed    x0,
      input longint signed    y0,
      input longint signed    x1,
      input longint signed    y1,
      input longint signed    x2,
      input longint signed    y2,
      input longint signed    x3,
      input longint signed    y3
   );
      element_result_type r;
      longint signed      dx;
      longint signed      dy;
      longint unsigned    m;
      m = 0;
      r.bad_figure = 1'b0;
      case (fig)
         emd_pkg::FIG_LINE: begin
            dx = x1 - x0;
            dy = y1 - y0;
            m = root_floor(longint'(dx * dx + dy * dy));
         end
         emd_pkg::FIG_TRI: begin
            m = cross_abs(x1 - x0, y1 - y0, x2 - x0, y2 - y0) >> 1;
         end
         emd_pkg::FIG_QUAD: begin
            // Corner triangles at node 1 and node 3, summed before halving.
            m = (cross_abs(x0 - x1, y0 - y1, x2 - x1, y2 - y1)
               + cross_abs(x2 - x3, y2 - y3, x0 - x3, y0 - y3)) >> 1;
         end
         default: begin
            r.bad_figure = 1'b1;
         end
      endcase
      if (m > MEASURE_MAX) begin
         m = MEASURE_MAX;
      end
      r.measure = m[emd_pkg::MEASURE_WIDTH-1:0];
      return r;
   endfunction

   // Compare each strobed result with the oldest prediction, then log new items.
   always @(posedge clock) begin
      element_result_type got;
      element_result_type want;
      if (reset) begin
         pending_measures.delete();
         mismatch_count <= 0;
         checked_count  <= 0;
         pending_count  <= 0;
      end else begin
         if (rsp_valid) begin
            got.measure    = rsp_measure;
            got.bad_figure = rsp_bad_figure;
            if (pending_measures.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("%0t: unexpected result: measure %0d bad_figure %0b",
                     $realtime, got.measure, got.bad_figure);
               end
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = pending_measures.pop_front();
               checked_count <= checked_count + 1;
               if (got.measure !== want.measure ||
                   got.bad_figure !== want.bad_figure) begin
                  if (mismatch_count < 10) begin
                     $display({"%0t: measure expected %0d got %0d, ",
                               "bad_figure expected %0b got %0b"},
                        $realtime, want.measure, got.measure, want.bad_figure,
                        got.bad_figure);
                  end
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (start && !busy) begin
            pending_measures.insert(pending_measures.size(),
               measure_element(emd_pkg::fig_type'(req_figure),
                  req_x0, req_y0, req_x1, req_y1, req_x2, req_y2, req_x3, req_y3));
         end
         pending_count <= pending_measures.size();
      end
   end

endmodule

// ===== dv/testbench.sv =====
// Top of the element_measure_2d testbench: clock, reset, element stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

   typedef logic signed [emd_pkg::COORD_WIDTH-1:0] coord_type;

   localparam coord_type C_MIN = {1'b1, {(emd_pkg::COORD_WIDTH-1){1'b0}}};
   localparam coord_type C_MAX = {1'b0, {(emd_pkg::COORD_WIDTH-1){1'b1}}};
   localparam coord_type ONE   = coord_type'(1 << emd_pkg::FRACTION_BITS);
   localparam int RANDOM_ITEMS = 1650;
   localparam int QUIET_TAIL   = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_figure = '0;
   coord_type req_x0 = '0, req_y0 = '0, req_x1 = '0, req_y1 = '0;
   coord_type req_x2 = '0, req_y2 = '0, req_x3 = '0, req_y3 = '0;
   logic rsp_valid;
   logic [emd_pkg::MEASURE_WIDTH-1:0] rsp_measure;
   logic rsp_bad_figure;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int figure_counts[4] = '{0, 0, 0, 0};

   // Node coordinates of the next element to send.
   coord_type node_x[4];
   coord_type node_y[4];

   always #5 clock = ~clock;

   element_measure_2d u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_figure     (req_figure),
      .req_x0         (req_x0),
      .req_y0         (req_y0),
      .req_x1         (req_x1),
      .req_y1         (req_y1),
      .req_x2         (req_x2),
      .req_y2         (req_y2),
      .req_x3         (req_x3),
      .req_y3         (req_y3),
      .rsp_valid      (rsp_valid),
      .rsp_measure    (rsp_measure),
      .rsp_bad_figure (rsp_bad_figure)
   );

   element_measure_2d_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_figure     (req_figure),
      .req_x0         (req_x0),
      .req_y0         (req_y0),
      .req_x1         (req_x1),
      .req_y1         (req_y1),
      .req_x2         (req_x2),
      .req_y2         (req_y2),
      .req_x3         (req_x3),
      .req_y3         (req_y3),
      .rsp_valid      (rsp_valid),
      .rsp_measure    (rsp_measure),
      .rsp_bad_figure (rsp_bad_figure),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   // Present the current nodes as one item and hold it until the block takes it.
   task automatic send_element(input emd_pkg::fig_type fig);
      logic held;
      req_figure <= fig;
      req_x0 <= node_x[0];
      req_y0 <= node_y[0];
      req_x1 <= node_x[1];
      req_y1 <= node_y[1];
      req_x2 <= node_x[2];
      req_y2 <= node_y[2];
      req_x3 <= node_x[3];
      req_y3 <= node_y[3];
      start  <= 1'b1;
      // Busy is sampled mid-cycle so the accepting edge is known without a race.
      do begin
         @(negedge clock);
         held = busy;
         @(posedge clock);
      end while (held);
      figure_counts[fig]++;
   endtask

   task automatic send_nodes(
      input emd_pkg::fig_type fig,
      input coord_type x0, y0, x1, y1, x2, y2, x3, y3
   );
      node_x = '{x0, x1, x2, x3};
      node_y = '{y0, y1, y2, y3};
      send_element(fig);
   endtask

   // Random idle gap on the input side.
   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clock);
   endtask

   // Coordinate near one end of the range.
   function automatic coord_type edge_coord();
      return $urandom_range(0, 1) ? coord_type'(C_MAX - $urandom_range(0, 3))
                                  : coord_type'(C_MIN + $urandom_range(0, 3));
   endfunction

   // Fill the nodes for one random element in one of several shapes.
   task automatic pick_nodes(output emd_pkg::fig_type fig);
      int kind;
      int k;
      coord_type cx;
      coord_type cy;
      coord_type dx;
      coord_type dy;
      kind = $urandom_range(0, 9);
      fig  = emd_pkg::fig_type'($urandom_range(0, 3));
      case (kind)
         0, 1, 2, 3: begin
            // Anywhere in the full coordinate range.
            for (int n = 0; n < 4; n++) begin
               node_x[n] = coord_type'($urandom);
               node_y[n] = coord_type'($urandom);
            end
         end
         4, 5: begin
            // A small element somewhere away from the range ends.
            cx = coord_type'($urandom_range(0, 8000000) - 4000000);
            cy = coord_type'($urandom_range(0, 8000000) - 4000000);
            for (int n = 0; n < 4; n++) begin
               node_x[n] = coord_type'(cx + ($urandom_range(0, 8191) - 4096));
               node_y[n] = coord_type'(cy + ($urandom_range(0, 8191) - 4096));
            end
         end
         6: begin
            // Nodes at or next to the corners of the range.
            for (int n = 0; n < 4; n++) begin
               node_x[n] = edge_coord();
               node_y[n] = edge_coord();
            end
         end
         7: begin
            // Collinear nodes, or all nodes on one point.
            cx = coord_type'($urandom_range(0, 4000000) - 2000000);
            cy = coord_type'($urandom_range(0, 4000000) - 2000000);
            dx = $urandom_range(0, 1) ?
                 coord_type'($urandom_range(0, 1000000) - 500000) : '0;
            dy = $urandom_range(0, 1) ?
                 coord_type'($urandom_range(0, 1000000) - 500000) : '0;
            node_x = '{cx, cx + dx, coord_type'(cx + 2 * dx), coord_type'(cx + 3 * dx)};
            node_y = '{cy, cy + dy, coord_type'(cy + 2 * dy), coord_type'(cy + 3 * dy)};
         end
         8: begin
            // A line whose length is an exact 3-4-5 multiple.
            fig = emd_pkg::FIG_LINE;
            k = $urandom_range(0, 2000000);
            node_x = '{coord_type'(-k), coord_type'(2 * k),
                       coord_type'($urandom), coord_type'($urandom)};
            node_y = '{coord_type'(-2 * k), coord_type'(2 * k),
                       coord_type'($urandom), coord_type'($urandom)};
            if ($urandom_range(0, 1)) begin
               node_x = '{node_x[1], node_x[0], node_x[2], node_x[3]};
               node_y = '{node_y[1], node_y[0], node_y[2], node_y[3]};
            end
         end
         default: begin
            // Mix of range ends and random values.
            for (int n = 0; n < 4; n++) begin
               node_x[n] = $urandom_range(0, 1) ? edge_coord() : coord_type'($urandom);
               node_y[n] = $urandom_range(0, 1) ? edge_coord() : coord_type'($urandom);
            end
         end
      endcase
   endtask

   // Reset, directed elements, random elements, then drain and report.
   initial begin
      emd_pkg::fig_type fig;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Lines: longest diagonal, zero length, exact length, sub-unit, one axis.
      send_nodes(emd_pkg::FIG_LINE, C_MIN, C_MIN, C_MAX, C_MAX, 0, 0, 0, 0);
      send_nodes(emd_pkg::FIG_LINE, 1234, -5678, 1234, -5678, C_MAX, C_MIN, C_MAX, C_MIN);
      send_nodes(emd_pkg::FIG_LINE, 0, 0, coord_type'(3 * ONE), coord_type'(4 * ONE),
                 C_MIN, C_MAX, C_MIN, C_MAX);
      send_nodes(emd_pkg::FIG_LINE, 0, 0, 1, 1, 0, 0, 0, 0);
      send_nodes(emd_pkg::FIG_LINE, C_MIN, 0, C_MAX, 0, 0, 0, 0, 0);
      send_nodes(emd_pkg::FIG_LINE, 0, C_MAX, 0, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN);
      // Triangles: largest, both orientations, truncated half, degenerate.
      send_nodes(emd_pkg::FIG_TRI, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, 0, 0);
      send_nodes(emd_pkg::FIG_TRI, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX);
      send_nodes(emd_pkg::FIG_TRI, 0, 0, 3, 0, 0, 1, C_MIN, C_MIN);
      send_nodes(emd_pkg::FIG_TRI, 0, 0, 0, 1, 1, 0, 0, 0);
      send_nodes(emd_pkg::FIG_TRI, -ONE, -ONE, 0, 0, ONE, ONE, C_MAX, C_MIN);
      send_nodes(emd_pkg::FIG_TRI, 77, 77, 77, 77, 77, 77, 77, 77);
      // Quadrilaterals: largest square, reversed order, bow tie, tiny, degenerate.
      send_nodes(emd_pkg::FIG_QUAD, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX);
      send_nodes(emd_pkg::FIG_QUAD, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
      send_nodes(emd_pkg::FIG_QUAD, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX);
      send_nodes(emd_pkg::FIG_QUAD, 0, 0, 1, 0, 1, 1, 0, 1);
      send_nodes(emd_pkg::FIG_QUAD, 0, 0, 1, 0, 1, 1, 1, 1);
      send_nodes(emd_pkg::FIG_QUAD, -5, -5, -5, -5, -5, -5, -5, -5);
      send_nodes(emd_pkg::FIG_QUAD, 0, 0, coord_type'(2 * ONE), 0, 0, ONE, 0, 0);
      // Unsupported figure code with full-scale and zero nodes.
      send_nodes(emd_pkg::FIG_BAD, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN);
      send_nodes(emd_pkg::FIG_BAD, 0, 0, 0, 0, 0, 0, 0, 0);

      // Random elements; the tail runs back to back.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
            idle_burst();
         end
         pick_nodes(fig);
         send_element(fig);
      end
      start <= 1'b0;

      // Wait for every predicted measure, then watch for stray results.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (emd_pkg::LATENCY + 10) @(posedge clock);

      $display("Run covered %0d elements: %0d lines, %0d triangles,",
         figure_counts[0] + figure_counts[1] + figure_counts[2] + figure_counts[3],
         figure_counts[emd_pkg::FIG_LINE], figure_counts[emd_pkg::FIG_TRI]);
      $display("%0d quadrilaterals, %0d unsupported; %0d measures checked, %0d mismatches.",
         figure_counts[emd_pkg::FIG_QUAD], figure_counts[emd_pkg::FIG_BAD],
         checked_count, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("element_measure_2d verification clean");
      end else begin
         $display("element_measure_2d verification failed");
      end
      $finish;
   end

   // Watchdog: a correct run needs well under a tenth of this.
   initial begin
      #(400_000 * 10);
      $display("Timeout with %0d measures still outstanding.", pending_count);
      $display("element_measure_2d verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/emd_pkg.sv
rtl/core/emd_operand.sv
rtl/core/emd_mult.sv
rtl/core/emd_root.sv
rtl/core/element_measure_2d.sv
dv/element_measure_2d_checker.sv
dv/testbench.sv
